>>> sv/tbk_pkg.sv
// ----------------------------------------------------------------------------
// tbk_pkg: shared types and constants for the countdown timer bank
// Timer entry layout, operation codes, sweep lengths and the mod-1000 step.
// ----------------------------------------------------------------------------
`default_nettype none

package tbk_pkg;

    localparam int NUM_TIMERS   = 16;
    localparam int COUNT_WIDTH  = 32;

    localparam int KIND_W       = 3;
    localparam int INDEX_W      = 4;
    localparam int VALUE_W      = 32;
    localparam int TIME_W       = 48;
    localparam int INC_W        = 10;
    localparam int SLICE_W      = 16;
    localparam int REM_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // common width for count compares, value truncation and remaining extension
    localparam int WIDE_W       = (COUNT_WIDTH > VALUE_W) ? COUNT_WIDTH : VALUE_W;

    localparam int IDX_W        = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SEL_W        = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

    // residue mod 1000, three time bits per step, MSB first
    localparam int MOD_BITS     = 3;
    localparam int MOD_STEPS    = TIME_W / MOD_BITS;
    localparam int RES_W        = 10;

    localparam int STEPS        = (NUM_TIMERS > MOD_STEPS) ? NUM_TIMERS : MOD_STEPS;
    localparam int STEP_W       = $clog2(STEPS);

    localparam logic [INC_W-1:0]   TICK_INC_RESET  = INC_W'(1);
    localparam logic [SLICE_W-1:0] SLICE_RELOAD_RESET = SLICE_W'(10);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK          = 3'd0,
        KIND_SET           = 3'd1,
        KIND_START         = 3'd2,
        KIND_SET_AND_START = 3'd3,
        KIND_QUERY         = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_INC     = 2'd0,
        CFG_SLICE_RELOAD = 2'd1
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic                   started;
    } timer_entry_t;

    typedef struct packed {
        kind_t              kind;
        logic               hit;
        logic [VALUE_W-1:0] value;
        logic [INC_W-1:0]   inc;
    } upd_op_t;

    typedef struct packed {
        logic             ok;
        logic             expired;
        logic [REM_W-1:0] remaining;
    } upd_stat_t;

    // (r * 8 + b) mod 1000 for r < 1000
    function automatic logic [RES_W-1:0] mod1000_step(input logic [RES_W-1:0] r,
                                                      input logic [MOD_BITS-1:0] b);
        logic [RES_W+MOD_BITS-1:0] v;
        logic [RES_W+MOD_BITS-1:0] sub;
        v = {r, b};
        if (v >= 13'd7000)      sub = 13'd7000;
        else if (v >= 13'd6000) sub = 13'd6000;
        else if (v >= 13'd5000) sub = 13'd5000;
        else if (v >= 13'd4000) sub = 13'd4000;
        else if (v >= 13'd3000) sub = 13'd3000;
        else if (v >= 13'd2000) sub = 13'd2000;
        else if (v >= 13'd1000) sub = 13'd1000;
        else                    sub = '0;
        v = v - sub;
        return v[RES_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/countdown_timer_bank.sv
// ----------------------------------------------------------------------------
// countdown_timer_bank: bank of countdown timers with slice counter and seconds
// Timers live in a ring of cells that rotates once per command; the head entry
// is updated as it wraps around, while the tick time is reduced mod 1000.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  command   | start / busy           | kind, timer_index, count_value, tick_time
//  result    | done (1-cycle strobe)  | ok, expired, remaining, slice_elapsed,
//            |                        | seconds_stamp
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  busy stays high while the sweep runs, which covers the longer of one full
//  rotation of the timer ring and the mod-1000 reduction of the 48-bit tick
//  time, three bits per cycle; done is high in the cycle in which busy drops.
//  A new command can be accepted in the cycle that carries done, but not
//  while busy. The receiver cannot stall the result.
//  Reset is asynchronous: all timers clear, slice counter loads its reload
//  value, config registers return to tick increment 1 and reload 10.
//  Config writes are taken only while idle with no command offered
//  (cfg_ready low when busy or start is high).
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_timer_bank
    import tbk_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // command transaction
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [KIND_W-1:0]      kind,
    input  wire logic [INDEX_W-1:0]     timer_index,
    input  wire logic [VALUE_W-1:0]     count_value,
    input  wire logic [TIME_W-1:0]      tick_time,

    // result transaction
    output logic                        done,
    output logic                        ok,
    output logic                        expired,
    output logic [REM_W-1:0]            remaining,
    output logic                        slice_elapsed,
    output logic [31:0]                 seconds_stamp,

    // configuration write
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                done_reg;
    logic                done_next;

    // configuration
    logic [INC_W-1:0]    tick_inc_reg;
    logic [SLICE_W-1:0]  slice_reload_reg;

    // slice counter and seconds timestamp
    logic [SLICE_W-1:0]  slice_reg;
    logic [SLICE_W-1:0]  slice_next;
    logic [31:0]         seconds_reg;
    logic [31:0]         seconds_next;

    // latched command
    kind_t               kind_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [VALUE_W-1:0]  value_reg;

    // tick time reduction: shifting copy plus running residue
    logic [TIME_W-1:0]   millis_reg;
    logic [TIME_W-1:0]   millis_next;
    logic [RES_W-1:0]    res_reg;
    logic [RES_W-1:0]    res_next;

    // result registers
    logic                ok_reg;
    logic                expired_reg;
    logic [REM_W-1:0]    remaining_reg;
    logic                elapsed_reg;
    logic                elapsed_next;

    logic                accept;
    logic                cfg_write;
    logic                last_step;
    logic                ring_active;
    logic                mod_active;
    logic [SEL_W-1:0]    head_sel;
    logic [SEL_W-1:0]    cmd_sel;
    logic                index_valid;

    upd_op_t             upd_op;
    upd_stat_t           upd_stat;
    timer_entry_t        upd_out;
    timer_entry_t        ring_q [NUM_TIMERS];

    assign accept      = start && (state_reg == ST_IDLE);
    assign cfg_write   = cfg_valid && cfg_ready;
    assign last_step   = (step_reg == STEP_W'(STEPS - 1));
    assign ring_active = (state_reg == ST_SWEEP) &&
                         ({1'b0, step_reg} < (STEP_W + 1)'(NUM_TIMERS));
    assign mod_active  = (state_reg == ST_SWEEP) &&
                         ({1'b0, step_reg} < (STEP_W + 1)'(MOD_STEPS));

    // after k shifts the head cell holds timer k
    assign head_sel    = SEL_W'(step_reg[IDX_W-1:0]);
    assign cmd_sel     = SEL_W'(index_reg);
    assign index_valid = ({1'b0, cmd_sel} < (SEL_W + 1)'(NUM_TIMERS));

    // ------------------------------------------------------------------
    // Timer ring: cell i takes from cell i+1, the last takes the updated head
    // ------------------------------------------------------------------
    always_comb
    begin
        upd_op.kind  = kind_reg;
        upd_op.hit   = index_valid && (head_sel == cmd_sel);
        upd_op.value = value_reg;
        upd_op.inc   = tick_inc_reg;
    end

    tbk_update u_update (
        .op   (upd_op),
        .din  (ring_q[0]),
        .dout (upd_out),
        .stat (upd_stat)
    );

    for (genvar gi = 0; gi < NUM_TIMERS; gi++)
    begin : g_ring
        timer_entry_t cell_din;
        if (gi == NUM_TIMERS - 1)
        begin : g_tail
            assign cell_din = upd_out;
        end
        else
        begin : g_body
            assign cell_din = ring_q[gi + 1];
        end

        tbk_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (ring_active),
            .din      (cell_din),
            .q        (ring_q[gi])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (last_step)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    // a config write never shares an edge with an accepted command
    always_comb
    begin
        busy      = (state_reg == ST_SWEEP);
        cfg_ready = (state_reg == ST_IDLE) && !start;
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        step_next    = step_reg;
        done_next    = 1'b0;
        millis_next  = millis_reg;
        res_next     = res_reg;
        slice_next   = slice_reg;
        elapsed_next = elapsed_reg;
        seconds_next = seconds_reg;

        if (accept)
        begin
            step_next    = '0;
            millis_next  = tick_time;
            res_next     = '0;
            elapsed_next = 1'b0;
            if (kind_t'(kind) == KIND_TICK)
            begin
                // slice reloads when the decrement would reach or pass zero
                if (SLICE_W'(tick_inc_reg) >= slice_reg)
                begin
                    slice_next   = slice_reload_reg;
                    elapsed_next = 1'b1;
                end
                else
                begin
                    slice_next = slice_reg - SLICE_W'(tick_inc_reg);
                end
            end
        end
        else if (state_reg == ST_SWEEP)
        begin
            step_next = step_reg + STEP_W'(1);
            if (mod_active)
            begin
                res_next    = mod1000_step(res_reg, millis_reg[TIME_W-1 -: MOD_BITS]);
                millis_next = {millis_reg[TIME_W-MOD_BITS-1:0], {MOD_BITS{1'b0}}};
            end
            if (last_step)
            begin
                done_next = 1'b1;
                if ((kind_reg == KIND_TICK) && (res_next == '0))
                    seconds_next = seconds_reg + 32'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            done_reg         <= 1'b0;
            tick_inc_reg     <= TICK_INC_RESET;
            slice_reload_reg <= SLICE_RELOAD_RESET;
            slice_reg        <= SLICE_RELOAD_RESET;
            seconds_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            done_reg    <= done_next;
            slice_reg   <= slice_next;
            seconds_reg <= seconds_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_TICK_INC:     tick_inc_reg     <= cfg_data[INC_W-1:0];
                    CFG_SLICE_RELOAD: slice_reload_reg <= cfg_data[SLICE_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        millis_reg  <= millis_next;
        res_reg     <= res_next;
        elapsed_reg <= elapsed_next;
        if (accept)
        begin
            kind_reg      <= kind_t'(kind);
            index_reg     <= timer_index;
            value_reg     <= count_value;
            ok_reg        <= 1'b0;
            expired_reg   <= 1'b0;
            remaining_reg <= '0;
        end
        else if (ring_active && upd_op.hit)
        begin
            // addressed timer passing the head: capture its status
            ok_reg        <= upd_stat.ok;
            expired_reg   <= upd_stat.expired;
            remaining_reg <= upd_stat.remaining;
        end
    end

    assign done          = done_reg;
    assign ok            = ok_reg;
    assign expired       = expired_reg;
    assign remaining     = remaining_reg;
    assign slice_elapsed = elapsed_reg;
    assign seconds_stamp = seconds_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a preceding sweep");

    a_accept_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start a sweep");

    a_result_kinds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(ok && expired) && !(ok && slice_elapsed) && !(expired && slice_elapsed))
        else $error("result mixes fields of different command kinds");

    a_seconds_change_only_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(seconds_stamp))
        else $error("seconds timestamp moved outside a result");

endmodule

`default_nettype wire

>>> sv/tbk_cell.sv
// ----------------------------------------------------------------------------
// tbk_cell: one timer slot of the rotating ring
// Holds count and started mark; loads its neighbor's entry when shifting.
// ----------------------------------------------------------------------------
`default_nettype none

module tbk_cell
    import tbk_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         shift_en,
    input  wire timer_entry_t din,
    output timer_entry_t      q
);

    timer_entry_t entry_reg;
    timer_entry_t entry_next;

    always_comb
    begin
        entry_next = shift_en ? din : entry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

>>> sv/tbk_update.sv
// ----------------------------------------------------------------------------
// tbk_update: entry update at the head of the ring
// Applies tick decrement, set, start or query to the entry passing by.
// ----------------------------------------------------------------------------
`default_nettype none

module tbk_update
    import tbk_pkg::*;
(
    input  wire upd_op_t      op,
    input  wire timer_entry_t din,
    output timer_entry_t      dout,
    output upd_stat_t         stat
);

    logic [WIDE_W-1:0] cnt_wide;
    logic [WIDE_W-1:0] inc_wide;
    logic [WIDE_W-1:0] val_wide;
    logic              nonzero;
    logic              can_load;
    logic              val_nonzero;

    always_comb
    begin
        cnt_wide    = WIDE_W'(din.count);
        inc_wide    = WIDE_W'(op.inc);
        val_wide    = WIDE_W'(op.value);
        nonzero     = (din.count != '0);
        can_load    = !(din.started && nonzero);
        val_nonzero = (val_wide[COUNT_WIDTH-1:0] != '0);

        dout = din;
        stat = '0;

        unique case (op.kind)
            KIND_TICK:
            begin
                if (din.started && nonzero)
                begin
                    if (inc_wide >= cnt_wide)
                        dout.count = '0;
                    else
                        dout.count = din.count - inc_wide[COUNT_WIDTH-1:0];
                end
            end
            KIND_SET:
            begin
                if (op.hit && can_load)
                begin
                    dout.count   = val_wide[COUNT_WIDTH-1:0];
                    dout.started = 1'b0;
                    stat.ok      = 1'b1;
                end
            end
            KIND_START:
            begin
                if (op.hit && !din.started && nonzero)
                begin
                    dout.started = 1'b1;
                    stat.ok      = 1'b1;
                end
            end
            KIND_SET_AND_START:
            begin
                if (op.hit && can_load)
                begin
                    dout.count   = val_wide[COUNT_WIDTH-1:0];
                    dout.started = val_nonzero;
                    stat.ok      = val_nonzero;
                end
            end
            KIND_QUERY:
            begin
                if (op.hit)
                begin
                    stat.expired   = !nonzero;
                    stat.remaining = cnt_wide[REM_W-1:0];
                end
            end
            default:
            begin
                dout = din;
            end
        endcase
    end

endmodule

`default_nettype wire
